// ----- rtl/core/ppiu_pkg.sv -----
// Shared types, constants and helper functions for the palette index unpacker.
package ppiu_pkg;

  localparam int WORD_BITS      = 64;
  localparam int SECTION_BLOCKS = 4096;
  localparam int MIN_INDEX_BITS = 4;
  localparam int PALETTE_CAP    = 4096;
  localparam int LEN_W          = 13;
  localparam int IDX_W          = 12;
  localparam int CNT_W          = 13;
  localparam int WID_W          = 4;
  localparam int PER_W          = 5;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  // One classified word as it travels from the front end to the unpacker.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last_word;
    logic                 active;
    logic [WID_W-1:0]     width;
    logic [PER_W-1:0]     per_word;
  } ppiu_entry_t;

  // Index width: bit length of (len - 1) with len capped, floored at the minimum.
  function automatic logic [WID_W-1:0] index_width(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] capped;
    logic [IDX_W-1:0] span;
    logic [WID_W-1:0] w;
    capped = (len > LEN_W'(PALETTE_CAP)) ? LEN_W'(PALETTE_CAP) : len;
    span   = IDX_W'(capped - LEN_W'(1));
    w      = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (span[b]) begin
        w = WID_W'(b + 1);
      end
    end
    if (w < WID_W'(MIN_INDEX_BITS)) begin
      w = WID_W'(MIN_INDEX_BITS);
    end
    return w;
  endfunction

  // Indices that fit in one word for each width.
  function automatic logic [PER_W-1:0] per_word_count(input logic [WID_W-1:0] w);
    logic [PER_W-1:0] n;
    case (w)
      4'd4:    n = 5'd16;
      4'd5:    n = 5'd12;
      4'd6:    n = 5'd10;
      4'd7:    n = 5'd9;
      4'd8:    n = 5'd8;
      4'd9:    n = 5'd7;
      4'd10:   n = 5'd6;
      4'd11:   n = 5'd5;
      4'd12:   n = 5'd5;
      default: n = 5'd16;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/packed_palette_index_unpacker.sv -----
// Top level of the packed palette index unpacker.
// Usage:
//   Write palette_len at byte address 0 through the APB-style port while the
//   block is idle; it sets the index width (at least 4 bits, at most 12).
//   Each transaction on the in_ channel carries one 64-bit packed word and a
//   last-word flag. The out_ channel returns one transaction per index, low
//   bits first, with the running section count and a flag on the final index
//   of the word.
// Path: a word goes through a queue entry and word_r to the output register.
// Throughput: the unpacker emits one index per cycle when not stalled; a word
//   yields up to 64/width indices (5 to 16); words that yield nothing are
//   dropped. A two-entry queue lets the input accept words while one unpacks.
// Reset: palette_len and the section count go to zero, the queue empties and
//   no output is valid.
// Stall: when out_ready is low the output register holds its transaction,
//   the unpacker pauses, and in_ready drops once the queue is full.
module packed_palette_index_unpacker
  import ppiu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_packed_word,
  input  logic                 in_last_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_state_index,
  output logic [CNT_W-1:0]     out_decoded_count,
  output logic                 out_last
);

  logic [LEN_W-1:0] palette_len_r, palette_len_nxt;
  logic             cfg_write;
  logic             queue_full;
  logic             push;
  ppiu_entry_t      push_entry;
  logic             pop;
  logic             head_valid;
  ppiu_entry_t      head_entry;

  // Register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(palette_len_r) : '0;

  always_comb begin
    palette_len_nxt = cfg_write ? pwdata[LEN_W-1:0] : palette_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_len_r <= '0;
    end else begin
      palette_len_r <= palette_len_nxt;
    end
  end

  ppiu_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packed_word (in_packed_word),
    .in_last_word   (in_last_word),
    .palette_len    (palette_len_r),
    .queue_full     (queue_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  ppiu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ppiu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_entry        (head_entry),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_state_index   (out_state_index),
    .out_decoded_count (out_decoded_count),
    .out_last          (out_last)
  );

endmodule

// ----- rtl/core/ppiu_queue.sv -----
// Two-entry queue between the front end and the unpacker.
module ppiu_queue
  import ppiu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ppiu_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output ppiu_entry_t head_entry
);

  ppiu_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/ppiu_front.sv -----
// Front end: accepts packed words and classifies them by the current palette length.
module ppiu_front
  import ppiu_pkg::*;
(
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_packed_word,
  input  logic                 in_last_word,
  input  logic [LEN_W-1:0]     palette_len,
  input  logic                 queue_full,
  output logic                 push,
  output ppiu_entry_t          push_entry
);

  logic [WID_W-1:0] width;

  // Accept whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the word: index width, indices per word, and whether any are produced
  always_comb begin
    width                = index_width(palette_len);
    push_entry.word      = in_packed_word;
    push_entry.last_word = in_last_word;
    push_entry.active    = (palette_len > LEN_W'(1));
    push_entry.width     = width;
    push_entry.per_word  = per_word_count(width);
  end

endmodule

// ----- rtl/core/ppiu_back.sv -----
// Back end: emits one index per cycle from the current word unless the output stalls, and tracks the section count.
module ppiu_back
  import ppiu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ppiu_entry_t      head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_state_index,
  output logic [CNT_W-1:0] out_decoded_count,
  output logic             out_last
);

  logic                 busy_r, busy_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 last_word_r, last_word_nxt;
  logic                 active_r, active_nxt;
  logic [WID_W-1:0]     width_r, width_nxt;
  logic [PER_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     index_r, index_nxt;
  logic [CNT_W-1:0]     dcount_r, dcount_nxt;
  logic                 olast_r, olast_nxt;

  logic             drop;
  logic             emit;
  logic             emit_last;
  logic             finish;
  logic [IDX_W-1:0] mask;

  assign out_valid         = out_valid_r;
  assign out_state_index   = index_r;
  assign out_decoded_count = dcount_r;
  assign out_last          = olast_r;

  // Words that produce nothing: small palette or full section
  assign drop      = busy_r && (!active_r || (count_r == CNT_W'(SECTION_BLOCKS)));
  assign emit      = busy_r && !drop && (!out_valid_r || out_ready);
  assign emit_last = (rem_r == PER_W'(1)) || (count_r == CNT_W'(SECTION_BLOCKS - 1));
  assign finish    = drop || (emit && emit_last);
  assign pop       = head_valid && (!busy_r || finish);
  assign mask      = ~({IDX_W{1'b1}} << width_r);

  always_comb begin
    busy_nxt      = busy_r;
    word_nxt      = word_r;
    last_word_nxt = last_word_r;
    active_nxt    = active_r;
    width_nxt     = width_r;
    rem_nxt       = rem_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    index_nxt     = index_r;
    dcount_nxt    = dcount_r;
    olast_nxt     = olast_r;

    // Drop the output transaction once taken
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Emit one index and advance through the word
    if (emit) begin
      out_valid_nxt = 1'b1;
      index_nxt     = word_r[IDX_W-1:0] & mask;
      dcount_nxt    = count_r + CNT_W'(1);
      olast_nxt     = emit_last;
      count_nxt     = count_r + CNT_W'(1);
      word_nxt      = word_r >> width_r;
      rem_nxt       = rem_r - PER_W'(1);
    end

    // Close the word; the section ends after a marked last word
    if (finish) begin
      busy_nxt = 1'b0;
      if (last_word_r) begin
        count_nxt = '0;
      end
    end

    // Load the next word from the queue
    if (pop) begin
      busy_nxt      = 1'b1;
      word_nxt      = head_entry.word;
      last_word_nxt = head_entry.last_word;
      active_nxt    = head_entry.active;
      width_nxt     = head_entry.width;
      rem_nxt       = head_entry.per_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    last_word_r <= last_word_nxt;
    active_r    <= active_nxt;
    width_r     <= width_nxt;
    rem_r       <= rem_nxt;
    index_r     <= index_nxt;
    dcount_r    <= dcount_nxt;
    olast_r     <= olast_nxt;
  end

endmodule

// ----- verif/packed_palette_index_unpacker_tb.sv -----
// Testbench for the packed palette index unpacker: random and directed words, checked per index.
`timescale 1ns / 100ps

module packed_palette_index_unpacker_tb;
  import ppiu_pkg::*;

  localparam logic [2:0] PALETTE_LEN_ADDR = 3'd0;

  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic                 last_word;
  } packed_word_t;

  typedef struct {
    logic [IDX_W-1:0] state_index;
    logic [CNT_W-1:0] decoded_count;
    logic             last;
  } palette_index_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [WORD_BITS-1:0] in_packed_word;
  logic                 in_last_word;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_state_index;
  logic [CNT_W-1:0]     out_decoded_count;
  logic                 out_last;

  // Words waiting to be sent and indices waiting to come out
  packed_word_t   pending_words[$];
  palette_index_t expected_indices[$];

  // Shadow of the block state
  logic [LEN_W-1:0] palette_len;
  int               section_count;

  int mismatch_count;
  bit send_idle_on;
  bit sink_idle_on;
  int send_gap;
  int sink_stall;

  packed_palette_index_unpacker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packed_word    (in_packed_word),
    .in_last_word      (in_last_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_state_index   (out_state_index),
    .out_decoded_count (out_decoded_count),
    .out_last          (out_last)
  );

  always #4 clk = ~clk;

  // Index width for a palette length: smallest power of two covering it, floored
  function automatic int index_bits(input logic [LEN_W-1:0] len);
    int capped;
    int bits;
    capped = (len > PALETTE_CAP) ? PALETTE_CAP : int'(len);
    bits = 0;
    while (bits < 31 && (1 << bits) < capped) bits++;
    if (bits < MIN_INDEX_BITS) bits = MIN_INDEX_BITS;
    return bits;
  endfunction

  // Split one word into the indices it yields and advance the section count
  function automatic void unpack_word(input logic [WORD_BITS-1:0] word,
                                      input logic last_word);
    int               bits;
    int               per_word;
    logic [63:0]      mask;
    palette_index_t   idx;
    if (palette_len > 1) begin
      bits     = index_bits(palette_len);
      per_word = WORD_BITS / bits;
      mask     = (64'd1 << bits) - 64'd1;
      for (int b = 0; b < per_word && section_count < SECTION_BLOCKS; b++) begin
        section_count++;
        idx.state_index   = IDX_W'((word >> (b * bits)) & mask);
        idx.decoded_count = CNT_W'(section_count);
        idx.last          = (b == per_word - 1) || (section_count == SECTION_BLOCKS);
        expected_indices.push_back(idx);
      end
    end
    if (last_word) section_count = 0;
  endfunction

  // Gap length: mostly none or short, sometimes long
  function automatic int pick_gap(input bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return {32'h0, $urandom} << $urandom_range(0, 32);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Driver: present queued words, hold each until its transaction completes
  always @(posedge clk) begin
    packed_word_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) unpack_word(in_packed_word, in_last_word);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          item = pending_words.pop_front();
          in_packed_word <= item.word;
          in_last_word   <= item.last_word;
          in_valid       <= 1'b1;
          send_gap = pick_gap(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each index transaction and stall the output at random
  always @(posedge clk) begin
    palette_index_t exp_idx;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_indices.size() == 0) begin
          $display("%0t: unexpected index transaction: expected none, %s",
                   $time, "actual below");
          $display("%0t:   actual index %0d count %0d last %0d",
                   $time, out_state_index, out_decoded_count, out_last);
          mismatch_count++;
        end else begin
          exp_idx = expected_indices.pop_front();
          if (out_state_index !== exp_idx.state_index) begin
            $display("%0t: state_index mismatch: expected %0d, actual %0d",
                     $time, exp_idx.state_index, out_state_index);
            mismatch_count++;
          end
          if (out_decoded_count !== exp_idx.decoded_count) begin
            $display("%0t: decoded_count mismatch: expected %0d, actual %0d",
                     $time, exp_idx.decoded_count, out_decoded_count);
            mismatch_count++;
          end
          if (out_last !== exp_idx.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $time, exp_idx.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 99) < 15) begin
        sink_stall = pick_gap(1'b1);
        out_ready <= (sink_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Write palette_len: setup cycle, then access cycle
  task automatic write_palette_len(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PALETTE_LEN_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    palette_len = value[LEN_W-1:0];
  endtask

  // Wait until every word is taken and every index has come out, then let
  // words that yield nothing drain from the queue
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_indices.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic queue_word(input logic [WORD_BITS-1:0] word, input logic last_word);
    packed_word_t item;
    item.word      = word;
    item.last_word = last_word;
    pending_words.push_back(item);
  endtask

  initial begin
    int          dir_lens[16];
    logic [31:0] cfg_value;
    int          kind;
    dir_lens = '{1, 2, 16, 17, 32, 33, 64, 65, 129, 257, 513, 1025, 2048, 2049,
                 4096, 8191};
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_packed_word = '0;
    in_last_word   = 1'b0;
    out_ready      = 1'b0;
    palette_len    = '0;
    section_count  = 0;
    mismatch_count = 0;
    send_idle_on   = 1'b0;
    sink_idle_on   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Palette length left at reset: words yield nothing
    queue_word('1, 1'b0);
    queue_word('1, 1'b1);
    wait_quiet();

    // One word of all ones per width boundary, plus zero and mixed words at length 2
    foreach (dir_lens[i]) begin
      write_palette_len(dir_lens[i]);
      queue_word('1, i[0]);
      if (dir_lens[i] == 2) begin
        queue_word('0, 1'b0);
        queue_word(64'h0123_4567_89AB_CDEF, 1'b1);
      end
      wait_quiet();
    end

    // Random phases with varied palette lengths and idling
    for (int phase = 0; phase < 10; phase++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0:       cfg_value = $urandom_range(0, 1);
        7:       cfg_value = PALETTE_CAP;
        8:       cfg_value = $urandom_range(PALETTE_CAP + 1, 8191);
        9:       cfg_value = ($urandom << LEN_W) | $urandom_range(0, 8191);
        default: cfg_value = $urandom_range(2, 1 << $urandom_range(1, 12));
      endcase
      send_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      write_palette_len(cfg_value);
      for (int n = 0; n < 16; n++) queue_word(pick_word(), $urandom_range(0, 7) == 0);
      wait_quiet();
    end

    if (mismatch_count == 0 && expected_indices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
